[rtl/dlt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlt_pkg: shared types and constants of the DFA longest-match tokenizer
// Field widths, request codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package dlt_pkg;

	localparam int REQ_W    = 2;
	localparam int SEL_W    = 3;
	localparam int IDX_W    = 12;
	localparam int VAL_W    = 12;
	localparam int BYTE_W   = 8;
	localparam int STATE_W  = 8;
	localparam int BASE_W   = 12;
	localparam int TOK_W    = 8;
	localparam int LEN_W    = 6;
	localparam int WIDE_W   = 17;

	localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;

	typedef enum logic [REQ_W-1:0] {
		REQ_WRITE = 2'd0,
		REQ_BYTE  = 2'd1,
		REQ_FLUSH = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [SEL_W-1:0] {
		SEL_BASE    = 3'd0,
		SEL_CHECK   = 3'd1,
		SEL_NEXT    = 3'd2,
		SEL_DEFAULT = 3'd3,
		SEL_ACCEPT  = 3'd4
	} sel_t;

	typedef struct packed {
		logic tbl_wr;
		logic buf_wr;
		logic scan_rd;
		logic look;
		logic take_next;
		logic take_dflt;
		logic acc_upd;
		logic emit;
		logic trunc;
		logic flush_end;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic scan_more;
		logic count_nz;
		logic match;
		logic next_alive;
		logic dflt_alive;
		logic depth_ok;
		logic at_max;
		logic hold_v;
		logic out_free;
	} stat_t;

endpackage

[rtl/dfa_longest_match_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfa_longest_match_tokenizer: table-driven longest-match tokenizer
// Table write, text byte and flush items in; token id/length results out.
// ----------------------------------------------------------------------------
// A table write is done in IDLE. A text byte is accepted in IDLE; each
// byte that extends the scan then passes SCAN (buffer and base read), LOOK
// (check/next read), CHK (compare, accept read) and ACC. A refused byte
// passes SCAN, LOOK and CHK, and each default fallback repeats LOOK and CHK.
// Each token is emitted in EMIT, and closing the item takes a last buffer
// check in SCAN, then the final result in FIN. Bytes replayed after a token
// are scanned again the same way, through dependent single-port table reads.
// Results leave through an output register behind a one-result holding stage,
// so the final result of an item is marked last; a busy output stalls the
// scan only when both are full.
// ----------------------------------------------------------------------------
module dfa_longest_match_tokenizer
	import dlt_pkg::*;
#(
	parameter int NUM_STATES     = 256,
	parameter int NUM_ENTRIES    = 4096,
	parameter int TOKEN_MAX      = 32,
	parameter int FALLBACK_DEPTH = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [SEL_W-1:0]  table_select,
	input  logic [IDX_W-1:0]  table_index,
	input  logic [VAL_W-1:0]  table_value,
	input  logic [BYTE_W-1:0] text_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [TOK_W-1:0]  token_id,
	output logic [LEN_W-1:0]  token_length,
	output logic              token_truncated,
	output logic              last
);

	cmd_t  cmd;
	stat_t st;

	dlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.st       (st),
		.cmd      (cmd)
	);

	dlt_datapath #(
		.NUM_STATES     (NUM_STATES),
		.NUM_ENTRIES    (NUM_ENTRIES),
		.TOKEN_MAX      (TOKEN_MAX),
		.FALLBACK_DEPTH (FALLBACK_DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.table_select    (table_select),
		.table_index     (table_index),
		.table_value     (table_value),
		.text_byte       (text_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.token_id        (token_id),
		.token_length    (token_length),
		.token_truncated (token_truncated),
		.last            (last)
	);

endmodule

[rtl/dlt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlt_ctrl: tokenizer sequencer
// Walks each buffered byte through the table lookups, decides reject,
// fallback and emit, and closes each byte or flush item with its final result when one is held.
// ----------------------------------------------------------------------------
module dlt_ctrl
	import dlt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [REQ_W-1:0] req_type,
	input  stat_t            st,
	output cmd_t             cmd
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SCAN = 7'b0000010,
		ST_LOOK = 7'b0000100,
		ST_CHK  = 7'b0001000,
		ST_ACC  = 7'b0010000,
		ST_EMIT = 7'b0100000,
		ST_FIN  = 7'b1000000
	} fsm_t;

	fsm_t state_q, state_d;
	logic flush_q, flush_d;
	logic trunc_q, trunc_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		flush_d = flush_q;
		trunc_d = trunc_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (req_t'(req_type))
						REQ_WRITE: cmd.tbl_wr = 1'b1;
						REQ_BYTE: begin
							cmd.buf_wr = 1'b1;
							flush_d    = 1'b0;
							state_d    = ST_SCAN;
						end
						REQ_FLUSH: begin
							flush_d = 1'b1;
							state_d = ST_SCAN;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (st.scan_more) begin
					cmd.scan_rd = 1'b1;
					state_d     = ST_LOOK;
				end else if (flush_q && st.count_nz) begin
					trunc_d = 1'b0;
					state_d = ST_EMIT;
				end else begin
					cmd.flush_end = flush_q;
					state_d       = ST_FIN;
				end
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = ST_CHK;
			end
			ST_CHK: begin
				trunc_d = 1'b0;
				if (st.match) begin
					if (st.next_alive) begin
						cmd.take_next = 1'b1;
						state_d       = ST_ACC;
					end else begin
						state_d = ST_EMIT;
					end
				end else if (st.depth_ok && st.dflt_alive) begin
					cmd.take_dflt = 1'b1;
					state_d       = ST_LOOK;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_ACC: begin
				cmd.acc_upd = 1'b1;
				if (st.at_max) begin
					// Still alive at the buffer limit: force the token out.
					trunc_d = 1'b1;
					state_d = ST_EMIT;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_EMIT: begin
				if (!st.hold_v || st.out_free) begin
					cmd.emit  = 1'b1;
					cmd.trunc = trunc_q;
					state_d   = ST_SCAN;
				end
			end
			ST_FIN: begin
				if (!st.hold_v) begin
					state_d = ST_IDLE;
				end else if (st.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			flush_q <= 1'b0;
			trunc_q <= 1'b0;
		end else begin
			state_q <= state_d;
			flush_q <= flush_d;
			trunc_q <= trunc_d;
		end
	end

endmodule

[rtl/dlt_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlt_datapath: tables, replay buffer and scan registers
// Holds the five DFA tables, the circular replay buffer, the scan state,
// one held result and the output register.
// ----------------------------------------------------------------------------
module dlt_datapath
	import dlt_pkg::*;
#(
	parameter int NUM_STATES     = 256,
	parameter int NUM_ENTRIES    = 4096,
	parameter int TOKEN_MAX      = 32,
	parameter int FALLBACK_DEPTH = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             st,
	input  logic [SEL_W-1:0]  table_select,
	input  logic [IDX_W-1:0]  table_index,
	input  logic [VAL_W-1:0]  table_value,
	input  logic [BYTE_W-1:0] text_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [TOK_W-1:0]  token_id,
	output logic [LEN_W-1:0]  token_length,
	output logic              token_truncated,
	output logic              last
);

	localparam int SLIM   = (NUM_STATES < 256) ? NUM_STATES : 256;
	localparam int SAW    = (SLIM > 1) ? $clog2(SLIM) : 1;
	localparam int SDEPTH = 1 << SAW;
	localparam int EAW    = $clog2(NUM_ENTRIES);
	localparam int EDEPTH = 1 << EAW;
	localparam int BAW    = (TOKEN_MAX > 1) ? $clog2(TOKEN_MAX) : 1;
	localparam int BDEPTH = 1 << BAW;
	localparam int CW     = $clog2(TOKEN_MAX + 1);
	localparam int DW     = (FALLBACK_DEPTH > 0) ? $clog2(FALLBACK_DEPTH + 1) : 1;

	localparam logic [WIDE_W-1:0] SLIM_W   = WIDE_W'(SLIM);
	localparam logic [WIDE_W-1:0] NSTATE_W = WIDE_W'(NUM_STATES);
	localparam logic [WIDE_W-1:0] NENT_W   = WIDE_W'(NUM_ENTRIES);

	logic [BASE_W-1:0]  base_mem [SDEPTH];
	logic [STATE_W-1:0] dflt_mem [SDEPTH];
	logic [TOK_W-1:0]   acc_mem  [SDEPTH];
	logic [STATE_W-1:0] chk_mem  [EDEPTH];
	logic [STATE_W-1:0] next_mem [EDEPTH];
	logic [BYTE_W-1:0]  buf_mem  [BDEPTH];

	logic [BASE_W-1:0]  base_rd_q;
	logic [STATE_W-1:0] dflt_rd_q, chk_rd_q, next_rd_q;
	logic [TOK_W-1:0]   acc_rd_q;
	logic [BYTE_W-1:0]  buf_rd_q;

	logic [BAW-1:0]     head_q;
	logic [CW-1:0]      count_q, scan_q, best_len_q;
	logic [STATE_W-1:0] cur_s_q;
	logic [DW-1:0]      depth_q;
	logic [TOK_W-1:0]   best_tok_q;
	logic               best_nl_q, first_nl_q, als_q, ix_ok_q;

	logic               hold_v_q;
	logic [TOK_W-1:0]   hold_tok_q;
	logic [CW-1:0]      hold_len_q;
	logic               hold_tr_q;
	logic               out_valid_q;

	logic [WIDE_W-1:0]  tidx_w, ix_w;
	logic               wr_state_ok, wr_entry_ok;
	logic [STATE_W-1:0] s_rd;
	logic               s_rd_en;
	logic [CW-1:0]      em_len;
	logic [TOK_W-1:0]   em_tok;
	logic               em_nl, out_free;

	assign tidx_w      = WIDE_W'(table_index);
	assign wr_state_ok = cmd.tbl_wr && (tidx_w < SLIM_W);
	assign wr_entry_ok = cmd.tbl_wr && (tidx_w < NENT_W);
	assign ix_w        = WIDE_W'(base_rd_q) + WIDE_W'(buf_rd_q);

	// Base/default read: fallback, else start state at a fresh scan, else current state.
	always_comb begin
		s_rd_en = cmd.scan_rd || cmd.take_dflt;
		if (cmd.take_dflt) begin
			s_rd = dflt_rd_q;
		end else if (scan_q == '0) begin
			s_rd = als_q ? STATE_W'(2) : STATE_W'(1);
		end else begin
			s_rd = cur_s_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_state_ok && table_select == SEL_BASE) begin
			base_mem[table_index[SAW-1:0]] <= table_value[BASE_W-1:0];
		end
		if (wr_state_ok && table_select == SEL_DEFAULT) begin
			dflt_mem[table_index[SAW-1:0]] <= table_value[STATE_W-1:0];
		end
		if (wr_state_ok && table_select == SEL_ACCEPT) begin
			acc_mem[table_index[SAW-1:0]] <= table_value[TOK_W-1:0];
		end
		if (s_rd_en) begin
			base_rd_q <= base_mem[s_rd[SAW-1:0]];
			dflt_rd_q <= dflt_mem[s_rd[SAW-1:0]];
		end
		if (cmd.take_next) begin
			acc_rd_q <= acc_mem[next_rd_q[SAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_entry_ok && table_select == SEL_CHECK) begin
			chk_mem[tidx_w[EAW-1:0]] <= table_value[STATE_W-1:0];
		end
		if (wr_entry_ok && table_select == SEL_NEXT) begin
			next_mem[tidx_w[EAW-1:0]] <= table_value[STATE_W-1:0];
		end
		if (cmd.look) begin
			chk_rd_q  <= chk_mem[ix_w[EAW-1:0]];
			next_rd_q <= next_mem[ix_w[EAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.buf_wr && count_q < CW'(TOKEN_MAX)) begin
			buf_mem[head_q + count_q[BAW-1:0]] <= text_byte;
		end
		if (cmd.scan_rd) begin
			buf_rd_q <= buf_mem[head_q + scan_q[BAW-1:0]];
		end
	end

	always_comb begin
		em_len = (best_len_q != '0) ? best_len_q : CW'(1);
		em_tok = (best_len_q != '0) ? best_tok_q : '0;
		em_nl  = (best_len_q != '0) ? best_nl_q : first_nl_q;
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			scan_q      <= '0;
			best_len_q  <= '0;
			best_tok_q  <= '0;
			best_nl_q   <= 1'b0;
			first_nl_q  <= 1'b0;
			cur_s_q     <= STATE_W'(1);
			depth_q     <= '0;
			als_q       <= 1'b1;
			ix_ok_q     <= 1'b0;
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.buf_wr && count_q < CW'(TOKEN_MAX)) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.scan_rd) begin
				cur_s_q <= s_rd;
				depth_q <= '0;
				scan_q  <= scan_q + CW'(1);
			end
			if (cmd.look) begin
				ix_ok_q <= ix_w < NENT_W;
				if (scan_q == CW'(1)) begin
					first_nl_q <= buf_rd_q == NEWLINE_CODE;
				end
			end
			if (cmd.take_dflt) begin
				cur_s_q <= dflt_rd_q;
				depth_q <= depth_q + DW'(1);
			end
			if (cmd.take_next) begin
				cur_s_q <= next_rd_q;
			end
			if (cmd.acc_upd && acc_rd_q != '0) begin
				best_tok_q <= acc_rd_q;
				best_len_q <= scan_q;
				best_nl_q  <= buf_rd_q == NEWLINE_CODE;
			end
			if (cmd.emit) begin
				// The previously held result is known not to be the item's last.
				if (hold_v_q) begin
					out_valid_q <= 1'b1;
				end
				hold_v_q   <= 1'b1;
				head_q     <= head_q + em_len[BAW-1:0];
				count_q    <= count_q - em_len;
				als_q      <= em_nl;
				best_len_q <= '0;
				best_tok_q <= '0;
				scan_q     <= '0;
			end
			if (cmd.flush_end) begin
				als_q <= 1'b1;
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
				hold_v_q    <= 1'b0;
			end
		end
	end

	// Result payload registers, loaded alongside the valid flags above.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			hold_tok_q <= em_tok;
			hold_len_q <= em_len;
			hold_tr_q  <= cmd.trunc;
		end
		if ((cmd.emit && hold_v_q) || cmd.fin) begin
			token_id        <= hold_tok_q;
			token_length    <= LEN_W'(hold_len_q);
			token_truncated <= hold_tr_q;
			last            <= cmd.fin;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		st            = '0;
		st.scan_more  = scan_q < count_q;
		st.count_nz   = count_q != '0;
		st.match      = ix_ok_q && (chk_rd_q == cur_s_q);
		st.next_alive = (next_rd_q != '0) && (WIDE_W'(next_rd_q) < NSTATE_W);
		st.dflt_alive = (dflt_rd_q != '0) && (WIDE_W'(dflt_rd_q) < NSTATE_W);
		st.depth_ok   = depth_q < DW'(FALLBACK_DEPTH);
		st.at_max     = scan_q >= CW'(TOKEN_MAX);
		st.hold_v     = hold_v_q;
		st.out_free   = out_free;
	end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the DFA longest-match tokenizer
// Loads a small lexer into the DFA tables, then drives directed and random
// table writes, text bytes and flushes, with both sides stalling at random in
// the random runs. A predictor mirrors the tables and the scan, and every
// token result is compared with the oldest expected token.
// ----------------------------------------------------------------------------
module tb_top;
	import dlt_pkg::*;

	localparam int N_STATES   = 256;
	localparam int N_ENTRIES  = 4096;
	localparam int MAX_TOKEN  = 32;
	localparam int MAX_FALL   = 1;
	localparam int HALF_CLK   = 4;
	localparam int CYCLE_CAP  = 2000000;
	localparam int DRAIN_WAIT = 400;
	localparam int ROW_LOW    = 4064;
	localparam int ROW_TOP    = 4095;

	// Character classes of the test lexer.
	localparam logic [BYTE_W-1:0] CH_A    = 8'd1;
	localparam logic [BYTE_W-1:0] CH_B    = 8'd2;
	localparam logic [BYTE_W-1:0] CH_0    = 8'd3;
	localparam logic [BYTE_W-1:0] CH_1    = 8'd4;
	localparam logic [BYTE_W-1:0] CH_EQ   = 8'd5;
	localparam logic [BYTE_W-1:0] CH_HASH = 8'd6;

	typedef struct {
		logic [TOK_W-1:0] id;
		logic [LEN_W-1:0] len;
		logic             trunc;
		logic             fin;
	} token_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [REQ_W-1:0]  req_type = REQ_NONE;
	logic [SEL_W-1:0]  table_select = '0;
	logic [IDX_W-1:0]  table_index = '0;
	logic [VAL_W-1:0]  table_value = '0;
	logic [BYTE_W-1:0] text_byte = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [TOK_W-1:0]  token_id;
	logic [LEN_W-1:0]  token_length;
	logic              token_truncated;
	logic              last;

	dfa_longest_match_tokenizer DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .table_select(table_select),
		.table_index(table_index), .table_value(table_value),
		.text_byte(text_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.token_id(token_id), .token_length(token_length),
		.token_truncated(token_truncated), .last(last)
	);

	always begin
		#HALF_CLK clk = 1'b1;
		#HALF_CLK clk = 1'b0;
	end

	int     cycles = 0;
	int     errors = 0;
	int     snd_idle = 0;
	int     rcv_idle = 0;
	int     hold_until = 0;
	token_t expected_tokens[$];

	// Mirror of the lexer tables and scan state.
	logic [BASE_W-1:0]  lx_base[N_STATES];
	logic [STATE_W-1:0] lx_check[N_ENTRIES];
	logic [STATE_W-1:0] lx_next[N_ENTRIES];
	logic [STATE_W-1:0] lx_dflt[N_STATES];
	logic [TOK_W-1:0]   lx_accept[N_STATES];
	logic [BYTE_W-1:0]  pend_bytes[MAX_TOKEN];
	int lx_state = 1, best_tok = 0, best_len = 0, scan_len = 0;
	int pend_cnt = 0, line_start = 1;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (cycles < hold_until)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= rcv_idle);
	end

	task automatic report(input string what);
		errors++;
		$display("MISMATCH at cycle %0d: %s", cycles, what);
	endtask

	// Outputs only change at rising edges, so the falling edge sees what the
	// next rising edge will take.
	always @(negedge clk) begin
		token_t t;
		if (arst_n && out_valid && out_ready) begin
			if (expected_tokens.size() == 0) begin
				report($sformatf("unexpected token id %0d len %0d", token_id, token_length));
			end else begin
				t = expected_tokens.pop_front();
				if (token_id !== t.id)
					report($sformatf("token_id %0d, expected %0d", token_id, t.id));
				if (token_length !== t.len)
					report($sformatf("token_length %0d, expected %0d", token_length, t.len));
				if (token_truncated !== t.trunc)
					report($sformatf("token_truncated %0b, expected %0b",
						token_truncated, t.trunc));
				if (last !== t.fin)
					report($sformatf("last %0b, expected %0b", last, t.fin));
			end
		end
	end

	function automatic bit step_state(input int c);
		int s, depth, ix;
		s = lx_state;
		depth = 0;
		ix = 0;
		forever begin
			if (s == 0 || s >= N_STATES) begin
				s = 0;
				break;
			end
			ix = int'(lx_base[s]) + c;
			if (ix < N_ENTRIES && int'(lx_check[ix]) == s) break;
			if (depth >= MAX_FALL) begin
				s = 0;
				break;
			end
			depth++;
			s = lx_dflt[s];
		end
		if (s != 0) begin
			s = lx_next[ix];
			if (s != 0 && lx_accept[s] != 0) begin
				best_tok = lx_accept[s];
				best_len = scan_len;
			end
		end
		lx_state = s;
		return s != 0;
	endfunction

	function automatic void emit_token(input bit trunc);
		token_t t;
		int len;
		len = best_len ? best_len : 1;
		if (len > pend_cnt) len = pend_cnt;
		t.id = best_len ? best_tok[TOK_W-1:0] : '0;
		t.len = len[LEN_W-1:0];
		t.trunc = trunc;
		t.fin = 1'b0;
		expected_tokens.push_back(t);
		line_start = (len > 0 && pend_bytes[len-1] == NEWLINE_CODE);
		for (int i = 0; i < pend_cnt - len; i++)
			pend_bytes[i] = pend_bytes[i+len];
		pend_cnt -= len;
		best_tok = 0;
		best_len = 0;
		scan_len = 0;
	endfunction

	function automatic void scan_pending();
		int c;
		while (scan_len < pend_cnt) begin
			if (scan_len == 0) lx_state = 1 + line_start;
			c = pend_bytes[scan_len];
			scan_len++;
			if (!step_state(c)) emit_token(1'b0);
			else if (scan_len >= MAX_TOKEN) emit_token(1'b1);
		end
	endfunction

	function automatic void predict_tokens(input logic [REQ_W-1:0] rq,
			input logic [SEL_W-1:0] sl, input logic [IDX_W-1:0] ix,
			input logic [VAL_W-1:0] vl, input logic [BYTE_W-1:0] ch);
		int n_before;
		token_t t;
		n_before = expected_tokens.size();
		case (rq)
			REQ_WRITE: begin
				case (sl)
					SEL_BASE:    if (ix < N_STATES) lx_base[ix] = vl;
					SEL_CHECK:   if (ix < N_ENTRIES) lx_check[ix] = vl[7:0];
					SEL_NEXT:    if (ix < N_ENTRIES) lx_next[ix] = vl[7:0];
					SEL_DEFAULT: if (ix < N_STATES) lx_dflt[ix] = vl[7:0];
					SEL_ACCEPT:  if (ix < N_STATES) lx_accept[ix] = vl[7:0];
					default: ;
				endcase
			end
			REQ_BYTE: begin
				if (pend_cnt < MAX_TOKEN) begin
					pend_bytes[pend_cnt] = ch;
					pend_cnt++;
				end
				scan_pending();
			end
			REQ_FLUSH: begin
				scan_pending();
				while (pend_cnt > 0) begin
					emit_token(1'b0);
					scan_pending();
				end
				line_start = 1;
				lx_state = 1;
			end
			default: ;
		endcase
		if (expected_tokens.size() > n_before) begin
			t = expected_tokens.pop_back();
			t.fin = 1'b1;
			expected_tokens.push_back(t);
		end
	endfunction

	// Called at a rising edge; returns at the rising edge that takes the item.
	task automatic send_item(input logic [REQ_W-1:0] rq, input logic [SEL_W-1:0] sl,
			input logic [IDX_W-1:0] ix, input logic [VAL_W-1:0] vl,
			input logic [BYTE_W-1:0] ch);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		table_select <= sl;
		table_index <= ix;
		table_value <= vl;
		text_byte <= ch;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		predict_tokens(rq, sl, ix, vl, ch);
		@(posedge clk);
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] ch);
		send_item(REQ_BYTE, '0, '0, '0, ch);
	endtask

	task automatic send_flush();
		send_item(REQ_FLUSH, '0, '0, '0, '0);
	endtask

	function automatic logic [BYTE_W-1:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 45) return 8'($urandom_range(CH_B, CH_A));
		if (r < 65) return 8'($urandom_range(CH_1, CH_0));
		if (r < 75) return CH_EQ;
		if (r < 82) return NEWLINE_CODE;
		if (r < 87) return CH_HASH;
		return 8'($urandom_range(255));
	endfunction

	// Every row ends inside the top block of entries, so any class past the
	// row's end looks up beyond the table.
	function automatic int row_base(input int s);
		case (s)
			1: return 4064;
			2: return 4076;
			3: return 4075;
			4: return 4077;
			5: return 4078;
			default: return ROW_TOP;
		endcase
	endfunction

	// Random writes keep every reachable state pointing at loaded entries.
	function automatic logic [VAL_W-1:0] safe_value(input logic [SEL_W-1:0] sl,
			input logic [IDX_W-1:0] ix, input logic [VAL_W-1:0] vl);
		case (sl)
			SEL_BASE: if (ix < N_STATES) return VAL_W'(ROW_LOW + int'(vl[4:0]));
			SEL_CHECK, SEL_NEXT, SEL_DEFAULT: return VAL_W'(int'(vl) % 9);
			default: ;
		endcase
		return vl;
	endfunction

	task automatic link(input int s, input logic [BYTE_W-1:0] c, input int target);
		send_item(REQ_WRITE, SEL_CHECK, IDX_W'(row_base(s) + int'(c)), VAL_W'(s), '0);
		send_item(REQ_WRITE, SEL_NEXT, IDX_W'(row_base(s) + int'(c)), VAL_W'(target), '0);
	endtask

	// Lexer: identifiers (1), numbers (2), "==" (3), "=" (4), newline (5),
	// and '#' at line start (6), which continues as an identifier through
	// a default fallback. Every entry that a scan can read is written.
	task automatic test_load_tables();
		logic [STATE_W-1:0] dflt;
		logic [TOK_W-1:0]   acc;
		for (int s = 1; s <= 8; s++) begin
			dflt = (s == 2) ? STATE_W'(1) : (s == 8) ? STATE_W'(3) : '0;
			case (s)
				3: acc = 8'd1;
				4: acc = 8'd2;
				5: acc = 8'd4;
				6: acc = 8'd3;
				7: acc = 8'd5;
				8: acc = 8'd6;
				default: acc = '0;
			endcase
			send_item(REQ_WRITE, SEL_BASE, IDX_W'(s), VAL_W'(row_base(s)), '0);
			send_item(REQ_WRITE, SEL_DEFAULT, IDX_W'(s), VAL_W'(dflt), '0);
			send_item(REQ_WRITE, SEL_ACCEPT, IDX_W'(s), VAL_W'(acc), '0);
		end
		for (int i = ROW_LOW; i <= ROW_TOP; i++)
			send_item(REQ_WRITE, SEL_CHECK, IDX_W'(i), '0, '0);
		link(1, CH_A, 3);
		link(1, CH_B, 3);
		link(1, CH_0, 4);
		link(1, CH_1, 4);
		link(1, CH_EQ, 5);
		link(1, NEWLINE_CODE, 7);
		link(2, CH_HASH, 8);
		link(3, CH_A, 3);
		link(3, CH_B, 3);
		link(3, CH_0, 3);
		link(3, CH_1, 3);
		link(4, CH_0, 4);
		link(4, CH_1, 4);
		link(5, CH_EQ, 6);
	endtask

	task automatic test_directed();
		send_flush();                                  // nothing buffered
		send_item(REQ_NONE, '1, '1, '1, '1);           // ignored request
		send_item(REQ_WRITE, SEL_BASE, '1, '1, '0);    // index beyond the table
		send_item(REQ_WRITE, 3'd7, 12'd3, '1, '0);     // unknown table
		send_item(REQ_WRITE, SEL_BASE, 12'd12, '1, '0); // lookups past the end
		send_byte(CH_A);
		send_byte(CH_EQ);
		send_byte(CH_EQ);
		send_byte(NEWLINE_CODE);
		send_byte(CH_HASH);
		send_byte(CH_B);
		send_byte(CH_1);
		send_byte(CH_EQ);
		send_byte(NEWLINE_CODE);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_1);
		send_byte(CH_1);
		send_byte(CH_HASH);
		send_byte(CH_EQ);
		send_flush();
	endtask

	task automatic test_truncation();
		for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(CH_B, CH_A)));
		send_byte(CH_1);
		send_byte(CH_EQ);
		send_flush();
	endtask

	task automatic test_random(input int n_items);
		int r;
		logic [SEL_W-1:0] sl;
		logic [IDX_W-1:0] ix;
		logic [VAL_W-1:0] vl;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(99);
			if (r < 82)
				send_byte(pick_char());
			else if (r < 87)
				send_flush();
			else if (r < 93) begin
				sl = SEL_W'($urandom_range(7));
				ix = IDX_W'($urandom_range(4095));
				vl = VAL_W'($urandom_range(4095));
				send_item(REQ_WRITE, sl, ix, safe_value(sl, ix, vl), '0);
			end else if (r < 96)
				send_item(REQ_NONE, SEL_W'($urandom_range(7)), IDX_W'($urandom_range(4095)),
					VAL_W'($urandom_range(4095)), 8'($urandom_range(255)));
			else if (r < 99)
				send_item(REQ_WRITE, SEL_ACCEPT, IDX_W'($urandom_range(8, 3)),
					VAL_W'($urandom_range(255)), '0);
			else
				for (int k = 0; k < 35; k++) send_byte(8'($urandom_range(CH_B, CH_A)));
		end
		send_flush();
	endtask

	task automatic test_backpressure();
		hold_until = cycles + 600;
		for (int i = 0; i < 40; i++) send_byte(pick_char());
		send_flush();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_tables();
		test_directed();
		test_truncation();
		snd_idle = 21;
		rcv_idle = 87;
		test_random(45);
		snd_idle = 87;
		rcv_idle = 21;
		test_random(45);
		snd_idle = 0;
		rcv_idle = 0;
		test_random(45);
		test_backpressure();
		in_valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
